/* src/rbap_pkg.sv */
// ---------------------------------------------------------------------------
// rbap_pkg: shared types and constants of the block-average pixelate unit
// Frame limits, beat payloads and the command/status bundles between the
// controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package rbap_pkg;

    // frame and grid limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int GRID_MAX   = 64;
    localparam int ADDR_W     = $clog2(GRID_MAX);

    // register file
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE    = 2'd2;
    localparam logic [10:0] FW_RESET = 11'd320;
    localparam logic [10:0] FH_RESET = 11'd240;
    localparam logic [6:0]  G_RESET  = 7'd8;

    // pixel fields
    localparam int RED_LSB   = 11;
    localparam int GREEN_LSB = 5;
    localparam logic [4:0] MASK5 = 5'h1F;
    localparam logic [5:0] MASK6 = 6'h3F;

    // accumulator and divider widths
    localparam int RSUM_W = 25;
    localparam int GSUM_W = 26;
    localparam int BSUM_W = 25;
    localparam int DIV_W  = 26;
    localparam int DEN_W  = 21;
    localparam int DIV_CW = $clog2(DIV_W);
    localparam int POS_W  = 17;

    typedef struct packed {
        logic [15:0] pixel;
        logic        frame_start;
    } t_in;

    typedef struct packed {
        logic [5:0] block_col;
        logic [5:0] block_row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_block;
    } t_out;

    typedef struct packed {
        logic take;
        logic add;
        logic load;
        logic cfg_start;
        logic cfg_fix;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic div_done;
        logic out_free;
    } t_stat;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ADD    = 7'b0000010,
        S_DIV    = 7'b0000100,
        S_OUT    = 7'b0001000,
        S_CSTART = 7'b0010000,
        S_CDIV   = 7'b0100000,
        S_CFIX   = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

/* src/rbap_div.sv */
// ---------------------------------------------------------------------------
// rbap_div: restoring radix-2 divider
// One quotient bit per cycle; done pulses in the cycle after the last step.
// ---------------------------------------------------------------------------
`default_nettype none

module rbap_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [rbap_pkg::DIV_W-1:0]    i_dividend,
    input  wire logic [rbap_pkg::DEN_W-1:0]    i_divisor,
    output logic                               o_done,
    output logic [rbap_pkg::DIV_W-1:0]         o_quot
);

    logic [rbap_pkg::DIV_W-1:0]  r_quot, n_quot;
    logic [rbap_pkg::DEN_W-1:0]  r_rem, n_rem;
    logic [rbap_pkg::DEN_W-1:0]  r_den;
    logic [rbap_pkg::DIV_CW-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [rbap_pkg::DEN_W:0]    w_sh;
    logic [rbap_pkg::DEN_W:0]    w_diff;

    // one trial subtraction
    always_comb begin
        w_sh   = {r_rem, r_quot[rbap_pkg::DIV_W-1]};
        w_diff = w_sh - {1'b0, r_den};
        if (w_sh >= {1'b0, r_den}) begin
            n_rem  = w_diff[rbap_pkg::DEN_W-1:0];
            n_quot = {r_quot[rbap_pkg::DIV_W-2:0], 1'b1};
        end else begin
            n_rem  = w_sh[rbap_pkg::DEN_W-1:0];
            n_quot = {r_quot[rbap_pkg::DIV_W-2:0], 1'b0};
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= rbap_pkg::DIV_CW'(rbap_pkg::DIV_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // operand and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_den  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

/* src/rbap_ctrl.sv */
// ---------------------------------------------------------------------------
// rbap_ctrl: sequencing state machine
// Steps each pixel through accept, accumulate and, at a block end, divide
// and output; it recalculates block geometry after reset and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

module rbap_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_in_valid,
    input  wire rbap_pkg::t_stat i_stat,
    output logic                 o_in_ready,
    output rbap_pkg::t_cmd       o_cmd
);

    rbap_pkg::t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            rbap_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = rbap_pkg::S_ADD;
                end
            end
            rbap_pkg::S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = i_stat.emit ? rbap_pkg::S_DIV : rbap_pkg::S_IDLE;
            end
            rbap_pkg::S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = rbap_pkg::S_OUT;
                end
            end
            rbap_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = rbap_pkg::S_IDLE;
                end
            end
            rbap_pkg::S_CSTART: begin
                o_cmd.cfg_start = 1'b1;
                n_state         = rbap_pkg::S_CDIV;
            end
            rbap_pkg::S_CDIV: begin
                if (i_stat.div_done) begin
                    n_state = rbap_pkg::S_CFIX;
                end
            end
            rbap_pkg::S_CFIX: begin
                o_cmd.cfg_fix = 1'b1;
                n_state       = rbap_pkg::S_IDLE;
            end
            default: begin
                n_state = rbap_pkg::S_CSTART;
            end
        endcase
        // a register write restarts the geometry calculation
        if (i_cfg_we) begin
            o_cmd      = '0;
            o_in_ready = 1'b0;
            n_state    = rbap_pkg::S_CSTART;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbap_pkg::S_CSTART;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* src/rbap_dp.sv */
// ---------------------------------------------------------------------------
// rbap_dp: pixelate datapath
// Registers, position counters, per-column sum memory, dividers and the
// output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rbap_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [rbap_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [rbap_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire rbap_pkg::t_in                      i_data,
    input  wire rbap_pkg::t_cmd                     i_cmd,
    input  wire logic                               i_ready,
    output rbap_pkg::t_stat                         o_stat,
    output logic                                    o_valid,
    output rbap_pkg::t_out                          o_data
);

    localparam int SUM_W = rbap_pkg::RSUM_W + rbap_pkg::GSUM_W + rbap_pkg::BSUM_W;

    // registers and geometry
    logic [10:0] r_fw, r_fh, r_bw, r_bh;
    logic [6:0]  r_g;
    logic [rbap_pkg::DEN_W-1:0] r_n;
    logic [10:0] w_fw, w_fh, w_bw, w_bh;
    logic [6:0]  w_g;

    // position
    logic [9:0]  r_cib, r_rib, c_cib, c_rib;
    logic [6:0]  r_cbc, r_cbr, c_cbc, c_cbr;
    logic [rbap_pkg::POS_W-1:0] r_x, r_y, c_x, c_y;

    // item in flight
    logic [15:0] r_pix;
    logic        r_act, r_emit, r_clr, r_last;
    logic [rbap_pkg::ADDR_W-1:0] r_c;
    logic [5:0]  r_row;
    logic        w_act, w_emit, w_row_end, w_frame_end;

    // sum memory
    logic [SUM_W-1:0] r_mem [rbap_pkg::GRID_MAX];
    logic [rbap_pkg::GRID_MAX-1:0] r_vld;
    logic [SUM_W-1:0] r_rd;
    logic             r_rd_ok;
    logic [rbap_pkg::RSUM_W-1:0] w_rs;
    logic [rbap_pkg::GSUM_W-1:0] w_gs;
    logic [rbap_pkg::BSUM_W-1:0] w_bs;

    // dividers
    logic                        w_div_start;
    logic [rbap_pkg::DIV_W-1:0]  w_dvd0, w_dvd1, w_dvd2;
    logic [rbap_pkg::DEN_W-1:0]  w_den;
    logic [rbap_pkg::DIV_W-1:0]  w_q0, w_q1, w_q2;
    logic                        w_done0, w_done1, w_done2;

    // output register
    logic           r_out_valid;
    rbap_pkg::t_out r_out;

    // saturated register values
    always_comb begin
        w_fw = (r_fw > 11'(rbap_pkg::MAX_WIDTH))  ? 11'(rbap_pkg::MAX_WIDTH)  : r_fw;
        w_fh = (r_fh > 11'(rbap_pkg::MAX_HEIGHT)) ? 11'(rbap_pkg::MAX_HEIGHT) : r_fh;
        w_g  = (r_g > 7'(rbap_pkg::GRID_MAX)) ? 7'(rbap_pkg::GRID_MAX) : r_g;
        w_bw = (w_g == '0) ? '0 : w_q0[10:0];
        w_bh = (w_g == '0) ? '0 : w_q1[10:0];
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= rbap_pkg::FW_RESET;
            r_fh <= rbap_pkg::FH_RESET;
            r_g  <= rbap_pkg::G_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rbap_pkg::REG_FRAME_WIDTH:  r_fw <= i_cfg_data;
                rbap_pkg::REG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                rbap_pkg::REG_GRID_SIZE:    r_g  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // current position, zeroed by a frame start mark
    always_comb begin
        if (i_data.frame_start) begin
            c_cib = '0; c_rib = '0; c_cbc = '0; c_cbr = '0; c_x = '0; c_y = '0;
        end else begin
            c_cib = r_cib; c_rib = r_rib; c_cbc = r_cbc; c_cbr = r_cbr;
            c_x = r_x; c_y = r_y;
        end
        w_act = (r_bw != '0) && (r_bh != '0) && (c_cbc < w_g) && (c_cbr < w_g);
        w_emit = w_act && ({1'b0, c_cib} == r_bw - 11'd1)
                       && ({1'b0, c_rib} == r_bh - 11'd1);
        w_row_end   = ({1'b0, c_x} + 18'd1) >= {7'd0, w_fw};
        w_frame_end = w_row_end && (({1'b0, c_y} + 18'd1) >= {7'd0, w_fh});
    end

    // position counters and geometry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cib <= '0; r_rib <= '0; r_cbc <= '0; r_cbr <= '0;
            r_x   <= '0; r_y   <= '0;
            r_bw  <= '0; r_bh  <= '0; r_n   <= '0;
        end else if (i_cmd.cfg_fix) begin
            r_bw <= w_bw;
            r_bh <= w_bh;
            r_n  <= rbap_pkg::DEN_W'(w_bw * w_bh);
            r_x  <= rbap_pkg::POS_W'(r_cbc * w_bw + {7'd0, r_cib});
            r_y  <= rbap_pkg::POS_W'(r_cbr * w_bh + {7'd0, r_rib});
        end else if (i_cmd.take) begin
            if (w_row_end) begin
                r_cib <= '0;
                r_cbc <= '0;
                r_x   <= '0;
                if (w_frame_end) begin
                    r_rib <= '0;
                    r_cbr <= '0;
                    r_y   <= '0;
                end else if ((c_cbr < w_g) && (r_bh != '0)
                             && ({1'b0, c_rib} >= r_bh - 11'd1)) begin
                    r_rib <= '0;
                    r_cbr <= c_cbr + 7'd1;
                    r_y   <= c_y + 1'b1;
                end else begin
                    r_rib <= c_rib + 10'd1;
                    r_cbr <= c_cbr;
                    r_y   <= c_y + 1'b1;
                end
            end else begin
                r_rib <= c_rib;
                r_cbr <= c_cbr;
                r_y   <= c_y;
                if ((c_cbc < w_g) && (r_bw != '0) && ({1'b0, c_cib} >= r_bw - 11'd1)) begin
                    r_cib <= '0;
                    r_cbc <= c_cbc + 7'd1;
                end else begin
                    r_cib <= c_cib + 10'd1;
                    r_cbc <= c_cbc;
                end
                r_x <= c_x + 1'b1;
            end
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_emit <= 1'b0;
            r_clr  <= 1'b0;
        end else if (i_cmd.take) begin
            r_act  <= w_act;
            r_emit <= w_emit;
            r_clr  <= w_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pix  <= i_data.pixel;
            r_c    <= c_cbc[rbap_pkg::ADDR_W-1:0];
            r_row  <= c_cbr[5:0];
            r_last <= (c_cbc == w_g - 7'd1) && (c_cbr == w_g - 7'd1);
        end
    end

    // accumulate
    always_comb begin
        w_rs = r_rd_ok ? r_rd[SUM_W-1 -: rbap_pkg::RSUM_W] : '0;
        w_gs = r_rd_ok ? r_rd[rbap_pkg::BSUM_W +: rbap_pkg::GSUM_W] : '0;
        w_bs = r_rd_ok ? r_rd[rbap_pkg::BSUM_W-1:0] : '0;
        w_rs = w_rs + rbap_pkg::RSUM_W'(r_pix[rbap_pkg::RED_LSB +: 5] & rbap_pkg::MASK5);
        w_gs = w_gs + rbap_pkg::GSUM_W'(r_pix[rbap_pkg::GREEN_LSB +: 6] & rbap_pkg::MASK6);
        w_bs = w_bs + rbap_pkg::BSUM_W'(r_pix[4:0] & rbap_pkg::MASK5);
    end

    // sum memory with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_rd <= r_mem[c_cbc[rbap_pkg::ADDR_W-1:0]];
        end
        if (i_cmd.add && r_act) begin
            r_mem[r_c] <= {w_rs, w_gs, w_bs};
        end
    end

    // entry valid bits, cleared by frame start and frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rd_ok <= 1'b0;
        end else if (i_cmd.take) begin
            r_rd_ok <= r_vld[c_cbc[rbap_pkg::ADDR_W-1:0]] && !i_data.frame_start;
            if (i_data.frame_start) begin
                r_vld <= '0;
            end
        end else if (i_cmd.add) begin
            if (r_clr) begin
                r_vld <= '0;
            end else if (r_act) begin
                r_vld[r_c] <= !r_emit;
            end
        end
    end

    // divider operands
    always_comb begin
        w_div_start = i_cmd.cfg_start || (i_cmd.add && r_emit);
        if (i_cmd.cfg_start) begin
            w_dvd0 = rbap_pkg::DIV_W'(w_fw);
            w_dvd1 = rbap_pkg::DIV_W'(w_fh);
            w_dvd2 = '0;
            w_den  = rbap_pkg::DEN_W'(w_g);
        end else begin
            w_dvd0 = rbap_pkg::DIV_W'(w_rs);
            w_dvd1 = w_gs;
            w_dvd2 = rbap_pkg::DIV_W'(w_bs);
            w_den  = r_n;
        end
    end

    rbap_div u_div_r (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd0),
        .i_divisor  (w_den),
        .o_done     (w_done0),
        .o_quot     (w_q0)
    );

    rbap_div u_div_g (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd1),
        .i_divisor  (w_den),
        .o_done     (w_done1),
        .o_quot     (w_q1)
    );

    rbap_div u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd2),
        .i_divisor  (w_den),
        .o_done     (w_done2),
        .o_quot     (w_q2)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.block_col  <= 6'(r_c);
            r_out.block_row  <= r_row;
            r_out.red        <= {w_q0[4:0], 3'b000};
            r_out.green      <= {w_q1[5:0], 2'b00};
            r_out.blue       <= {w_q2[4:0], 3'b000};
            r_out.last_block <= r_last;
        end
    end

    // status back to the controller
    always_comb begin
        o_stat.emit     = r_emit;
        o_stat.div_done = w_done0 && w_done1 && w_done2;
        o_stat.out_free = !r_out_valid || i_ready;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

/* src/rgb565_block_average_pixelate_unit.sv */
// ---------------------------------------------------------------------------
// rgb565_block_average_pixelate_unit: RGB565 block-average pixelator
// Averages raster-order RGB565 pixels over a square grid of blocks.
// ---------------------------------------------------------------------------
// A pixel that does not finish a block goes through accept, then the
// read-modify-write of its column sum. A pixel that finishes a block also
// waits for the three color averages, which come from 26-step restoring
// dividers running side by side, then the result goes to the output register,
// which waits for the sink without holding back later sums once loaded.
// After reset and after every register write the block works out block width
// and height on the same dividers, and the pixel count from them, and takes
// no pixel while it does so.
`default_nettype none

module rgb565_block_average_pixelate_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [rbap_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rbap_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire rbap_pkg::t_in                  i_data,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output rbap_pkg::t_out                      o_data
);

    rbap_pkg::t_cmd  w_cmd;
    rbap_pkg::t_stat w_stat;

    rbap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (i_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_ready),
        .o_cmd      (w_cmd)
    );

    rbap_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_data     (i_data),
        .i_cmd      (w_cmd),
        .i_ready    (i_ready),
        .o_stat     (w_stat),
        .o_valid    (o_valid),
        .o_data     (o_data)
    );

endmodule

`default_nettype wire

/* test/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top: testbench of the RGB565 block-average pixelate unit
// Drives pixel beats over several frame and grid settings, runs a behavioral
// model of the block sums and averages, and compares every result beat field
// by field. Both sides insert random gaps and stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 60;
    localparam int WATCHDOG_LIM = 4000;
    localparam int RANDOM_PIXELS = 1350;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [rbap_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [rbap_pkg::CFG_W-1:0]     i_cfg_data;
    logic                           i_valid;
    logic                           o_ready;
    rbap_pkg::t_in                  i_data;
    logic                           o_valid;
    logic                           i_ready;
    rbap_pkg::t_out                 o_data;

    rgb565_block_average_pixelate_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // model state: registers, position and per-column sums
    logic [10:0] mdl_fw, mdl_fh;
    logic [6:0]  mdl_grid;
    int unsigned pos_col, blk_col, pos_row, blk_row;
    logic [24:0] red_acc [rbap_pkg::GRID_MAX];
    logic [25:0] grn_acc [rbap_pkg::GRID_MAX];
    logic [24:0] blu_acc [rbap_pkg::GRID_MAX];

    rbap_pkg::t_out pending_blocks [$];
    int   err_cnt = 0;
    bit   sink_burst;

    function automatic void clear_frame();
        pos_col = 0;
        blk_col = 0;
        pos_row = 0;
        blk_row = 0;
        for (int k = 0; k < rbap_pkg::GRID_MAX; k++) begin
            red_acc[k] = '0;
            grn_acc[k] = '0;
            blu_acc[k] = '0;
        end
    endfunction

    // one pixel through the model; returns 1 when a block finishes
    function automatic bit average_pixel(input rbap_pkg::t_in d, output rbap_pkg::t_out r);
        int unsigned fw, fh, g, bw, bh, c;
        longint unsigned n, x, y;
        bit done;
        fw = (mdl_fw > rbap_pkg::MAX_WIDTH) ? rbap_pkg::MAX_WIDTH : mdl_fw;
        fh = (mdl_fh > rbap_pkg::MAX_HEIGHT) ? rbap_pkg::MAX_HEIGHT : mdl_fh;
        g  = (mdl_grid > rbap_pkg::GRID_MAX) ? rbap_pkg::GRID_MAX : mdl_grid;
        bw = (g != 0) ? fw / g : 0;
        bh = (g != 0) ? fh / g : 0;
        done = 1'b0;
        r = '0;
        if (d.frame_start) clear_frame();
        if (bw > 0 && bh > 0 && blk_col < g && blk_row < g) begin
            c = blk_col;
            red_acc[c] = red_acc[c] + d.pixel[15:11];
            grn_acc[c] = grn_acc[c] + d.pixel[10:5];
            blu_acc[c] = blu_acc[c] + d.pixel[4:0];
            if (pos_col == bw - 1 && pos_row == bh - 1) begin
                n = longint'(bw) * bh;
                r.block_col  = c[5:0];
                r.block_row  = blk_row[5:0];
                r.red        = 8'((longint'(red_acc[c]) / n) << 3);
                r.green      = 8'((longint'(grn_acc[c]) / n) << 2);
                r.blue       = 8'((longint'(blu_acc[c]) / n) << 3);
                r.last_block = (c == g - 1 && blk_row == g - 1);
                red_acc[c] = '0;
                grn_acc[c] = '0;
                blu_acc[c] = '0;
                done = 1'b1;
            end
        end
        // advance along the row, then down the frame
        x = longint'(blk_col) * bw + pos_col;
        if (x + 1 >= fw) begin
            pos_col = 0;
            blk_col = 0;
            y = longint'(blk_row) * bh + pos_row;
            if (y + 1 >= fh) begin
                clear_frame();
            end else if (blk_row < g && bh > 0 && pos_row >= bh - 1) begin
                pos_row = 0;
                blk_row++;
            end else begin
                pos_row++;
            end
        end else if (blk_col < g && bw > 0 && pos_col >= bw - 1) begin
            pos_col = 0;
            blk_col++;
        end else begin
            pos_col++;
        end
        return done;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one pixel beat; typed expectation replaces the model's when given
    task automatic send_pixel(input rbap_pkg::t_in d, input bit burst, input bit known,
                              input rbap_pkg::t_out typed);
        rbap_pkg::t_out r;
        int gap;
        gap = burst ? 0 : gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= d;
        if (average_pixel(d, r)) pending_blocks.push_back(known ? typed : r);
        do @(posedge i_clk); while (!o_ready);
    endtask

    // idle the block, then write all three registers
    task automatic set_frame(input logic [10:0] fw, input logic [10:0] fh,
                             input logic [6:0] g);
        i_valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= rbap_pkg::REG_FRAME_WIDTH;
        i_cfg_data <= fw;
        @(posedge i_clk);
        i_cfg_idx  <= rbap_pkg::REG_FRAME_HEIGHT;
        i_cfg_data <= fh;
        @(posedge i_clk);
        i_cfg_idx  <= rbap_pkg::REG_GRID_SIZE;
        i_cfg_data <= rbap_pkg::CFG_W'(g);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mdl_fw   = fw;
        mdl_fh   = fh;
        mdl_grid = g;
    endtask

    // result side: random stalls, compare against oldest expectation
    int hold = 0;
    always @(posedge i_clk) begin
        rbap_pkg::t_out e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_blocks.size() == 0) begin
                $error("unexpected result beat %h", o_data);
                err_cnt++;
            end else begin
                e = pending_blocks.pop_front();
                if (o_data.block_col != e.block_col) begin
                    $error("block_col exp %0d got %0d", e.block_col, o_data.block_col);
                    err_cnt++;
                end
                if (o_data.block_row != e.block_row) begin
                    $error("block_row exp %0d got %0d", e.block_row, o_data.block_row);
                    err_cnt++;
                end
                if (o_data.red != e.red) begin
                    $error("red exp %0d got %0d", e.red, o_data.red);
                    err_cnt++;
                end
                if (o_data.green != e.green) begin
                    $error("green exp %0d got %0d", e.green, o_data.green);
                    err_cnt++;
                end
                if (o_data.blue != e.blue) begin
                    $error("blue exp %0d got %0d", e.blue, o_data.blue);
                    err_cnt++;
                end
                if (o_data.last_block != e.last_block) begin
                    $error("last_block exp %0d got %0d", e.last_block, o_data.last_block);
                    err_cnt++;
                end
            end
        end
        if (hold > 0) begin
            hold   <= hold - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (!sink_burst && $urandom_range(0, 5) == 0) hold <= gap_len();
        end
    end

    // watchdog on cycles without any beat or register write
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIM) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // directed rows, run with a 2x2 frame and a single block
    typedef struct {
        logic [15:0]    px;
        bit             fs;
        bit             known;
        rbap_pkg::t_out blk;
    } t_row;

    t_row directed [] = '{
        '{16'hFFFF, 1'b1, 1'b0, '0},
        '{16'hFFFF, 1'b0, 1'b0, '0},
        '{16'hFFFF, 1'b0, 1'b0, '0},
        '{16'hFFFF, 1'b0, 1'b1, '{6'd0, 6'd0, 8'd248, 8'd252, 8'd248, 1'b1}},
        '{16'h0000, 1'b1, 1'b0, '0},
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h0000, 1'b0, 1'b1, '{6'd0, 6'd0, 8'd0, 8'd0, 8'd0, 1'b1}},
        // wraps into the next frame without a start mark
        '{16'h8410, 1'b0, 1'b0, '0},
        '{16'h7BEF, 1'b0, 1'b0, '0},
        '{16'h0821, 1'b0, 1'b0, '0},
        '{16'hF800, 1'b0, 1'b0, '0},
        // start mark in mid-frame restarts the sums
        '{16'h07E0, 1'b1, 1'b0, '0},
        '{16'h001F, 1'b0, 1'b0, '0},
        '{16'hAAAA, 1'b1, 1'b0, '0},
        '{16'h5555, 1'b0, 1'b0, '0},
        '{16'h1234, 1'b0, 1'b0, '0},
        '{16'hFEDC, 1'b0, 1'b0, '0}
    };

    // settings for the corners: oversized, zero-sized and single-block frames
    logic [28:0] corner_cfg [] = '{
        {11'd1024, 11'd1,    7'd1},
        {11'd64,   11'd64,   7'd64},
        {11'd2047, 11'd3,    7'd127},
        {11'd0,    11'd3,    7'd2},
        {11'd3,    11'd0,    7'd1},
        {11'd5,    11'd5,    7'd0},
        {11'd2,    11'd9,    7'd4},
        {11'd1,    11'd1,    7'd1},
        {11'd1,    11'd2047, 7'd1}
    };

    initial begin
        rbap_pkg::t_in d;
        logic [10:0] fw, fh;
        logic [6:0]  g;
        int   sent, n, frame_len, k;
        bit   burst;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_data     = '0;
        i_ready    = 1'b0;
        sink_burst = 1'b0;
        mdl_fw   = rbap_pkg::FW_RESET;
        mdl_fh   = rbap_pkg::FH_RESET;
        mdl_grid = rbap_pkg::G_RESET;
        clear_frame();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // a few pixels at the reset settings, then the directed table
        for (k = 0; k < 4; k++)
            send_pixel(rbap_pkg::t_in'({16'hFFFF, k == 0}), 1'b0, 1'b0, '0);
        set_frame(11'd2, 11'd2, 7'd1);
        foreach (directed[i])
            send_pixel(rbap_pkg::t_in'({directed[i].px, directed[i].fs}), i[0],
                       directed[i].known, directed[i].blk);

        // random part: mostly whole frames with random content
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            if ($urandom_range(0, 7) == 0) begin
                {fw, fh, g} = corner_cfg[$urandom_range(0, corner_cfg.size() - 1)];
            end else begin
                fw = $urandom_range(1, 12);
                fh = $urandom_range(1, 12);
                g  = $urandom_range(1, 4);
            end
            set_frame(fw, fh, g);
            frame_len = (fw > rbap_pkg::MAX_WIDTH ? rbap_pkg::MAX_WIDTH : fw)
                        * (fh > 16 ? 16 : fh);
            if (frame_len == 0) frame_len = 7;
            n = frame_len * $urandom_range(1, 3);
            if (n > 1100) n = 1100;
            if (n > RANDOM_PIXELS - sent) n = RANDOM_PIXELS - sent;
            burst = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            for (k = 0; k < n; k++) begin
                d.pixel = 16'($urandom);
                if (k % frame_len == 0) d.frame_start = ($urandom_range(0, 9) < 8);
                else d.frame_start = ($urandom_range(0, 39) == 0);
                send_pixel(d, burst, 1'b0, '0);
            end
            sent += n;
        end

        // drain
        i_valid <= 1'b0;
        sink_burst = 1'b1;
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
src/rbap_pkg.sv
src/rbap_div.sv
src/rbap_ctrl.sv
src/rbap_dp.sv
src/rgb565_block_average_pixelate_unit.sv
test/tb_top.sv
